### rtl/dhkv_pkg.sv
package dhkv_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = 17;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam logic [1:0] MARK_EMPTY   = 2'd0;
	localparam logic [1:0] MARK_FULL    = 2'd1;
	localparam logic [1:0] MARK_DELETED = 2'd2;

	localparam logic [1:0] STAT_DONE       = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND  = 2'd1;
	localparam logic [1:0] STAT_TABLE_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]       mark;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_word_t;

	typedef struct packed {
		logic             done;
		logic             hit;
		logic [VAL_W-1:0] value;
		logic [KEY_W-1:0] key;
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
	} result_t;

endpackage

### rtl/double_hash_key_value_table_core.sv
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_stall    action, lookup_key, new_value, slot_index
// output   out        out_valid / out_stall  hit, value_out, key_out, status, entry_count
//
// A transaction passes through the probe state once per slot probed (1 to TABLE_SIZE slots),
// then the finish state; a slot read by index probes a single slot. The slot memory has a single read port.
// After reset the slot memory is cleared one slot at a time with in_stall high.
// A finished result waits in the output register while the next transaction is taken.
module double_hash_key_value_table_core #(
	parameter int TABLE_SIZE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [dhkv_pkg::KEY_W-1:0]    lookup_key,
	input  logic [dhkv_pkg::VAL_W-1:0]    new_value,
	input  logic [15:0]                   slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [dhkv_pkg::VAL_W-1:0]    value_out,
	output logic [dhkv_pkg::KEY_W-1:0]    key_out,
	output logic [1:0]                    status,
	output logic [dhkv_pkg::CNT_W-1:0]    entry_count
);
	import dhkv_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);

	result_t          res;
	logic             out_free;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] raddr;
	slot_word_t       wdata;
	slot_word_t       rdata;
	logic             out_valid_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	dhkv_ctrl #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.lookup_key (lookup_key),
		.new_value  (new_value),
		.slot_index (slot_index),
		.out_free   (out_free),
		.res        (res),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata),
		.raddr      (raddr),
		.rdata      (rdata)
	);

	dhkv_slot_ram #(
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			hit         <= res.hit;
			value_out   <= res.value;
			key_out     <= res.key;
			status      <= res.status;
			entry_count <= res.count;
		end
	end

endmodule

### rtl/dhkv_slot_ram.sv
module dhkv_slot_ram #(
	parameter int DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  dhkv_pkg::slot_word_t  wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output dhkv_pkg::slot_word_t  rdata
);
	import dhkv_pkg::*;

	slot_word_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/dhkv_ctrl.sv
module dhkv_ctrl #(
	parameter int TABLE_SIZE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [dhkv_pkg::KEY_W-1:0]    lookup_key,
	input  logic [dhkv_pkg::VAL_W-1:0]    new_value,
	input  logic [15:0]                   slot_index,
	input  logic                          out_free,
	output dhkv_pkg::result_t             res,
	output logic                          we,
	output logic [$clog2(TABLE_SIZE)-1:0] waddr,
	output dhkv_pkg::slot_word_t          wdata,
	output logic [$clog2(TABLE_SIZE)-1:0] raddr,
	input  dhkv_pkg::slot_word_t          rdata
);
	import dhkv_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam logic [CNT_W-1:0] SIZE_C = CNT_W'(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_C = IDX_W'(TABLE_SIZE - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_PROBE = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       act_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic             idx_ok_q;
	logic [IDX_W-1:0] home_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] free_q;
	logic             free_vld_q;
	logic             found_q;
	slot_word_t       old_q;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             is_full;
	logic             is_del;
	logic             match;
	logic [IDX_W-1:0] pos_nx;
	logic             stop;
	logic             take_free;
	logic             finish;
	logic [CNT_W-1:0] count_nx;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign is_full   = (rdata.mark == MARK_FULL);
	assign is_del    = (rdata.mark == MARK_DELETED);
	assign match     = is_full && (rdata.key == key_q);
	assign pos_nx    = pos_q + step_q;
	assign take_free = !is_full && !free_vld_q;
	assign finish    = (state_q == ST_FIN) && out_free;
	assign stop      = (act_q == ACT_READ) || match || (!is_full && !is_del)
		|| (pos_nx == home_q);

	always_comb begin
		case (state_q)
			ST_IDLE: begin
				raddr = (action == ACT_READ) ? slot_index[IDX_W-1:0]
					: lookup_key[IDX_W-1:0];
			end
			ST_PROBE: raddr = pos_nx;
			default:  raddr = pos_q;
		endcase
	end

	always_comb begin
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = '{mark: MARK_FULL, key: key_q, value: val_q};
		count_nx = count_q;
		res      = '0;
		res.hit  = found_q;
		res.status = found_q ? STAT_DONE : STAT_NOT_FOUND;
		if (found_q) begin
			res.value = old_q.value;
		end
		if (act_q == ACT_READ && found_q) begin
			res.key = old_q.key;
		end
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (finish) begin
			case (act_q)
				ACT_INSERT: begin
					if (found_q) begin
						we = 1'b1;
					end else if (free_vld_q) begin
						we         = 1'b1;
						waddr      = free_q;
						count_nx   = count_q + CNT_W'(1);
						res.status = STAT_DONE;
					end else begin
						res.status = STAT_TABLE_FULL;
					end
				end
				ACT_REMOVE: begin
					if (found_q) begin
						we    = 1'b1;
						wdata = '{mark: MARK_DELETED, key: old_q.key, value: old_q.value};
						if (count_q != '0) begin
							count_nx = count_q - CNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.done  = finish;
		res.count = count_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			count_q    <= '0;
			free_vld_q <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == LAST_C) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_PROBE;
						free_vld_q <= 1'b0;
						found_q    <= 1'b0;
					end
				end
				ST_PROBE: begin
					if (take_free) begin
						free_vld_q <= 1'b1;
					end
					if (stop) begin
						state_q <= ST_FIN;
						found_q <= (act_q == ACT_READ) ? (idx_ok_q && is_full) : match;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						count_q <= count_nx;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action;
			key_q    <= lookup_key;
			val_q    <= new_value;
			idx_ok_q <= ({1'b0, slot_index} < SIZE_C);
			home_q   <= lookup_key[IDX_W-1:0];
			step_q   <= lookup_key[IDX_W+2:3] | IDX_W'(1);
			pos_q    <= (action == ACT_READ) ? slot_index[IDX_W-1:0]
				: lookup_key[IDX_W-1:0];
		end else if (state_q == ST_PROBE) begin
			if (take_free) begin
				free_q <= pos_q;
			end
			if (stop) begin
				old_q <= rdata;
			end else begin
				pos_q <= pos_nx;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SIZE_C)
		else $error("entry count exceeds table size");

	a_count_only_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIN) |=> (count_q == $past(count_q)))
		else $error("entry count changed outside of finish");

	a_accept_starts_probe: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_PROBE))
		else $error("accepted transaction did not start probing");

	a_write_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q != ST_CLEAR) |-> (wdata.mark == MARK_FULL || wdata.mark == MARK_DELETED))
		else $error("slot write outside clearing marks a slot empty");

	a_full_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(res.done && res.status == STAT_TABLE_FULL) |-> (act_q == ACT_INSERT))
		else $error("table full reported for a non-insert transaction");
`endif

endmodule
